[design/scsu_pkg.sv]
`default_nettype none

package scsu_pkg;

  localparam int unsigned PERIOD_W   = 12;
  localparam int unsigned LOAD_W     = 11;
  localparam int unsigned DIV_W      = 4;
  localparam int unsigned VOL_W      = 4;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned RATE_W     = 3;
  localparam int unsigned DUTY_W     = 2;
  localparam int unsigned OPC_W      = 2;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 12'hFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN_SWP = 12'd7;

  localparam logic [OPC_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OPC_W-1:0] OP_SAMPLE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_SHIFT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEGATE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DUTY    = 3'd5;

  // four eight-step patterns, step 0 in bit 0
  localparam logic [31:0] DUTY_TABLE = {8'b1111_1001, 8'b0001_1110,
                                        8'b0000_0110, 8'b0000_0010};

  function automatic logic duty_bit(input logic [DUTY_W-1:0] mode,
                                    input logic [STEP_W-1:0] step);
    return DUTY_TABLE[{mode, step}];
  endfunction

endpackage

`default_nettype wire

[design/square_channel_sweep_unit.sv]
// Channel   Direction  Contents
// s_axis    in         tuser: opcode; tdata: period_value, channel_active, volume, duty_step
// m_axis    out        tdata: sample, period_now, sweep_overflow
// apb       in/out     six control registers at byte address 4*i
//
// One request per cycle: the state and the result register are updated in the
// cycle of acceptance, one shift, add and compare on the 12-bit period.
// Synchronous reset clears period, divider, flag, registers and output valid.
// A stalled result holds in the output register; a new request is still taken
// in the cycle the held result is taken.
`default_nettype none

module square_channel_sweep_unit
  import scsu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // [1:0] opcode
  input  wire logic [OPC_W-1:0]      s_axis_tuser,
  // [10:0] period_value, [11] channel_active, [15:12] volume, [18:16] duty_step
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,

  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [3:0] sample, [15:4] period_now, [16] sweep_overflow
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  logic [SHIFT_W-1:0]  sweep_shift;
  logic                sweep_negate;
  logic [RATE_W-1:0]   sweep_rate;
  logic                sweep_enable;
  logic                channel_index;
  logic [DUTY_W-1:0]   duty_mode;

  logic [PERIOD_W-1:0] period, period_next;
  logic [DIV_W-1:0]    sweep_divider, sweep_divider_next;
  logic                overflow_flag, overflow_flag_next;
  logic [VOL_W-1:0]    sample_next;

  logic [LOAD_W-1:0]   in_period;
  logic                in_active;
  logic [VOL_W-1:0]    in_volume;
  logic [STEP_W-1:0]   in_step;

  logic [PERIOD_W-1:0] delta;
  logic [PERIOD_W:0]   sum_up;
  logic [PERIOD_W-1:0] sum_down;
  logic                accept;
  logic                cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_shift   <= '0;
      sweep_negate  <= 1'b0;
      sweep_rate    <= '0;
      sweep_enable  <= 1'b0;
      channel_index <= 1'b0;
      duty_mode     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SHIFT:   sweep_shift   <= pwdata[SHIFT_W-1:0];
        REG_NEGATE:  sweep_negate  <= pwdata[0];
        REG_RATE:    sweep_rate    <= pwdata[RATE_W-1:0];
        REG_ENABLE:  sweep_enable  <= pwdata[0];
        REG_CHANNEL: channel_index <= pwdata[0];
        REG_DUTY:    duty_mode     <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SHIFT:   prdata = {{(32-SHIFT_W){1'b0}}, sweep_shift};
      REG_NEGATE:  prdata = {31'd0, sweep_negate};
      REG_RATE:    prdata = {{(32-RATE_W){1'b0}}, sweep_rate};
      REG_ENABLE:  prdata = {31'd0, sweep_enable};
      REG_CHANNEL: prdata = {31'd0, channel_index};
      REG_DUTY:    prdata = {{(32-DUTY_W){1'b0}}, duty_mode};
      default:     prdata = '0;
    endcase
  end

  assign in_period = s_axis_tdata[10:0];
  assign in_active = s_axis_tdata[11];
  assign in_volume = s_axis_tdata[15:12];
  assign in_step   = s_axis_tdata[18:16];

  assign delta    = period >> sweep_shift;
  assign sum_up   = {1'b0, period} + {1'b0, delta};
  assign sum_down = period - delta + {{(PERIOD_W-1){1'b0}}, channel_index};

  always_comb begin
    period_next        = period;
    sweep_divider_next = sweep_divider;
    overflow_flag_next = overflow_flag;
    sample_next        = '0;
    unique case (s_axis_tuser)
      OP_TICK: begin
        if (sweep_divider <= DIV_W'(1)) begin
          sweep_divider_next = DIV_W'(sweep_rate) + DIV_W'(1);
          if (sweep_enable && (sweep_shift != '0) && (period > PERIOD_MIN_SWP)) begin
            overflow_flag_next = 1'b0;
            if (!sweep_negate) begin
              if (sum_up[PERIOD_W]) begin
                period_next        = PERIOD_MAX;
                overflow_flag_next = 1'b1;
              end else begin
                period_next = sum_up[PERIOD_W-1:0];
              end
            end else begin
              period_next = sum_down;
            end
          end
        end else begin
          sweep_divider_next = sweep_divider - DIV_W'(1);
        end
      end
      OP_LOAD: period_next = {1'b0, in_period};
      OP_SAMPLE: begin
        // muted when an upward sweep would pass the top of the range
        if (in_active && !(!sweep_negate && sum_up[PERIOD_W])
            && duty_bit(duty_mode, in_step)) begin
          sample_next = in_volume;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period        <= '0;
      sweep_divider <= '0;
      overflow_flag <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        period        <= period_next;
        sweep_divider <= sweep_divider_next;
        overflow_flag <= overflow_flag_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {{(OUT_DATA_W-VOL_W-PERIOD_W-1){1'b0}},
                       overflow_flag_next, period_next, sample_next};
    end
  end

endmodule

`default_nettype wire

[tb/sv/square_channel_sweep_unit_tb.sv]
`timescale 1ns / 1ps

module square_channel_sweep_unit_tb;
  import scsu_pkg::*;

  localparam logic [OPC_W-1:0] OP_NOP = 2'd3;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int STALL_CYCLES = 80;
  // duty patterns, step k in bit k
  localparam logic [3:0][7:0] DUTY_STEPS = {8'b1111_1001, 8'b0001_1110,
                                            8'b0000_0110, 8'b0000_0010};

  typedef struct packed {
    logic [OPC_W-1:0]  op;
    logic [LOAD_W-1:0] period_value;
    logic              active;
    logic [VOL_W-1:0]  volume;
    logic [STEP_W-1:0] step;
  } chan_req_t;

  typedef struct {
    logic [VOL_W-1:0]    sample;
    logic [PERIOD_W-1:0] period;
    logic                ovf;
  } chan_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OPC_W-1:0]      s_axis_tuser = '0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // register shadow
  logic [SHIFT_W-1:0] cfg_shift = '0;
  logic               cfg_negate = 1'b0;
  logic [RATE_W-1:0]  cfg_rate = '0;
  logic               cfg_enable = 1'b0;
  logic               cfg_channel = 1'b0;
  logic [DUTY_W-1:0]  cfg_duty = '0;

  // channel state
  logic [PERIOD_W-1:0] period_st = '0;
  logic [DIV_W-1:0]    divider_st = '0;
  logic                ovf_st = 1'b0;

  chan_req_t request_q[$];
  chan_out_t channel_results_q[$];
  int n_pushed = 0;
  int n_taken = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req = 0;
  int stall_done = 0;
  int hold_left = 0;
  int regime;
  int seg;
  int k;

  square_channel_sweep_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic step_channel(input chan_req_t rq);
    logic [PERIOD_W:0]   grown;
    logic [PERIOD_W-1:0] part;
    chan_out_t r;
    r.sample = '0;
    case (rq.op)
      OP_TICK: begin
        if (divider_st <= 1) begin
          divider_st = {1'b0, cfg_rate} + 4'd1;
          if (cfg_enable && cfg_shift != 0 && period_st > PERIOD_MIN_SWP) begin
            ovf_st = 1'b0;
            part = period_st >> cfg_shift;
            if (!cfg_negate) begin
              grown = {1'b0, period_st} + {1'b0, part};
              if (grown > {1'b0, PERIOD_MAX}) begin
                period_st = PERIOD_MAX;
                ovf_st = 1'b1;
              end else begin
                period_st = grown[PERIOD_W-1:0];
              end
            end else begin
              period_st = period_st - part + {{(PERIOD_W-1){1'b0}}, cfg_channel};
            end
          end
        end else begin
          divider_st = divider_st - 4'd1;
        end
      end
      OP_LOAD: period_st = {1'b0, rq.period_value};
      OP_SAMPLE: begin
        part = period_st >> cfg_shift;
        grown = {1'b0, period_st} + {1'b0, part};
        if (rq.active && !(!cfg_negate && grown > {1'b0, PERIOD_MAX}) &&
            DUTY_STEPS[cfg_duty][rq.step])
          r.sample = rq.volume;
      end
      default: ;
    endcase
    r.period = period_st;
    r.ovf = ovf_st;
    channel_results_q.push_back(r);
  endtask

  // sender
  always @(posedge clk) begin : sender
    chan_req_t rq;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        rq = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rq.op;
        s_axis_tdata <= {5'b0, rq.step, rq.volume, rq.active, rq.period_value};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on demand
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
      if (hold_left == 1) stall_done <= stall_done + 1;
    end else if (stall_req != stall_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= STALL_CYCLES;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin : monitor
    chan_req_t rq;
    chan_out_t want;
    chan_out_t got;
    logic moved;
    moved = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got.sample = m_axis_tdata[3:0];
        got.period = m_axis_tdata[15:4];
        got.ovf = m_axis_tdata[16];
        if (channel_results_q.size() == 0) begin
          $display("%0t: unrequested result, expected none got %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = channel_results_q.pop_front();
          if (got.sample !== want.sample) begin
            $display("%0t: sample expected %0d got %0d", $time, want.sample, got.sample);
            errors++;
          end
          if (got.period !== want.period) begin
            $display("%0t: period_now expected %0d got %0d", $time, want.period, got.period);
            errors++;
          end
          if (got.ovf !== want.ovf) begin
            $display("%0t: sweep_overflow expected %0d got %0d", $time, want.ovf, got.ovf);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        rq.op = s_axis_tuser;
        rq.period_value = s_axis_tdata[10:0];
        rq.active = s_axis_tdata[11];
        rq.volume = s_axis_tdata[15:12];
        rq.step = s_axis_tdata[18:16];
        step_channel(rq);
        n_taken++;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_CYCLES) @(negedge clk);
    $display("square_channel_sweep_unit regression: fail");
    $finish;
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SHIFT:   cfg_shift = val[SHIFT_W-1:0];
      REG_NEGATE:  cfg_negate = val[0];
      REG_RATE:    cfg_rate = val[RATE_W-1:0];
      REG_ENABLE:  cfg_enable = val[0];
      REG_CHANNEL: cfg_channel = val[0];
      REG_DUTY:    cfg_duty = val[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input int sh, input int ng, input int rt, input int en,
                            input int ch, input int dm);
    write_reg(REG_SHIFT, sh);
    write_reg(REG_NEGATE, ng);
    write_reg(REG_RATE, rt);
    write_reg(REG_ENABLE, en);
    write_reg(REG_CHANNEL, ch);
    write_reg(REG_DUTY, dm);
  endtask

  // extremes favoured
  function automatic int pick(input int top);
    int r;
    r = $urandom_range(3);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(top);
  endfunction

  task automatic push_req(input logic [OPC_W-1:0] op, input int pv, input int act,
                          input int vol, input int stp);
    chan_req_t rq;
    rq.op = op;
    rq.period_value = pv[LOAD_W-1:0];
    rq.active = act[0];
    rq.volume = vol[VOL_W-1:0];
    rq.step = stp[STEP_W-1:0];
    request_q.push_back(rq);
    n_pushed++;
  endtask

  task automatic push_random_req();
    int r;
    int pv;
    logic [OPC_W-1:0] op;
    r = $urandom_range(99);
    op = (r < 40) ? OP_TICK : (r < 60) ? OP_LOAD : (r < 95) ? OP_SAMPLE : OP_NOP;
    case ($urandom_range(3))
      0: pv = $urandom_range(15);
      1: pv = $urandom_range(2047, 1900);
      default: pv = $urandom_range(2047);
    endcase
    push_req(op, pv, $urandom_range(9) != 0, $urandom_range(15), $urandom_range(7));
  endtask

  // waits until every pushed request is taken and every result is checked
  task automatic drain();
    while (n_taken != n_pushed || channel_results_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);

    // upward sweep, saturation, mute, small periods, undefined opcode
    set_config(1, 0, 0, 1, 0, 0);
    push_req(OP_LOAD, 2047, 0, 0, 0);
    push_req(OP_SAMPLE, 0, 1, 15, 1);
    push_req(OP_TICK, 0, 0, 0, 0);
    push_req(OP_TICK, 0, 0, 0, 0);
    push_req(OP_SAMPLE, 0, 1, 15, 1);
    push_req(OP_LOAD, 0, 1, 15, 7);
    push_req(OP_TICK, 0, 0, 0, 0);
    push_req(OP_LOAD, 8, 0, 0, 0);
    push_req(OP_TICK, 0, 0, 0, 0);
    push_req(OP_LOAD, 7, 0, 0, 0);
    push_req(OP_TICK, 0, 0, 0, 0);
    push_req(OP_NOP, 11'h555, 1, 10, 5);
    push_req(OP_SAMPLE, 0, 0, 15, 1);
    drain();

    // downward sweep with channel add-back, slowest divider, last duty pattern
    set_config(7, 1, 7, 1, 1, 3);
    push_req(OP_LOAD, 2047, 1, 15, 7);
    for (k = 0; k < 9; k++) push_req(OP_TICK, 0, 0, 0, 0);
    push_req(OP_SAMPLE, 0, 1, 15, 0);
    push_req(OP_SAMPLE, 0, 1, 15, 1);
    drain();

    for (regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 21 : (regime == 1) ? 61 : 0;
      recv_idle_pct = (regime == 0) ? 61 : (regime == 1) ? 21 : 0;
      for (seg = 0; seg < 4; seg++) begin
        set_config(pick(7), pick(1), pick(7), $urandom_range(3) != 0, pick(1), pick(3));
        if (regime == 2 && seg == 0) stall_req++;
        for (k = 0; k < 33; k++) push_random_req();
        drain();
      end
    end

    repeat (4) @(negedge clk);
    if (errors == 0 && channel_results_q.size() == 0) begin
      $display("square_channel_sweep_unit regression: pass");
    end else begin
      $display("square_channel_sweep_unit regression: fail");
    end
    $finish;
  end

endmodule

[square_channel_sweep_unit.f]
design/scsu_pkg.sv
design/square_channel_sweep_unit.sv
tb/sv/square_channel_sweep_unit_tb.sv
